[design/fde_pkg.sv]
// fde_pkg: shared widths, payload words and the element record for the
// dof enumerator. no dependencies.
`timescale 1ns / 1ps
package fde_pkg;

	localparam int COORD_BITS = 16;
	localparam int DOF_BITS = 20;
	localparam int VKEY_BITS = 2 * COORD_BITS;
	localparam int EKEY_BITS = 4 * COORD_BITS;
	localparam int DEF_VERTEX_ENTRIES = 1024;
	localparam int DEF_EDGE_ENTRIES = 2048;
	localparam logic [DOF_BITS-1:0] DOF_MAX = {DOF_BITS{1'b1}};
	localparam logic [DOF_BITS-1:0] DOF_ONE = DOF_BITS'(1);
	localparam logic [2:0] ORDER_RESET = 3'd2;
	localparam logic [7:0] LEVEL_NUMBERED = 8'd1;
	localparam int SEG_INTERIOR = 8;

	typedef struct packed {
		logic mesh_start;
		logic [7:0] level;
		logic [COORD_BITS-1:0] left_x;
		logic [COORD_BITS-1:0] bottom_y;
		logic [COORD_BITS-1:0] right_x;
		logic [COORD_BITS-1:0] top_y;
	} item_t;

	typedef struct packed {
		logic [DOF_BITS-1:0] dof_number;
		logic [5:0] slot_index;
		logic last_of_element;
		logic overflow_error;
	} result_t;

	// corners 0..3, edge bases 4..7, interior base 8
	typedef struct packed {
		logic [8:0][DOF_BITS-1:0] vals;
		logic [2:0] pm1;
		logic [5:0] pm1sq;
		logic [5:0] last_slot;
		logic err;
	} elem_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_INT,
		ST_PUSH
	} front_state_t;

endpackage

[design/fde_front.sv]
// fde_front: accepts elements, scans vertex and edge tables, allocates numbers
// and builds one element record. depends on fde_pkg.
`timescale 1ns / 1ps
module fde_front import fde_pkg::*; #(
	parameter int VERTEX_ENTRIES = DEF_VERTEX_ENTRIES,
	parameter int EDGE_ENTRIES = DEF_EDGE_ENTRIES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  item_t item,
	input  logic [2:0] poly_order,
	output logic push,
	input  logic queue_full,
	output elem_t rec
);

	localparam int VC_W = $clog2(VERTEX_ENTRIES + 1);
	localparam int EC_W = $clog2(EDGE_ENTRIES + 1);
	localparam int VA_W = $clog2(VERTEX_ENTRIES);
	localparam int EA_W = $clog2(EDGE_ENTRIES);
	localparam int IDX_W = (EC_W > VC_W) ? EC_W : VC_W;

	front_state_t state_q, state_d;

	logic [COORD_BITS-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [2:0] pm1_q;
	logic [5:0] pm1sq_q;
	logic edge_q;
	logic [1:0] k_q;
	logic [IDX_W-1:0] idx_q;
	logic [VC_W-1:0] vcnt_q;
	logic [EC_W-1:0] ecnt_q;
	logic [DOF_BITS-1:0] next_q;
	logic err_q;
	logic [8:0][DOF_BITS-1:0] vals_q;

	logic [VKEY_BITS+DOF_BITS-1:0] vmem [VERTEX_ENTRIES];
	logic [EKEY_BITS+DOF_BITS-1:0] emem [EDGE_ENTRIES];
	logic [VKEY_BITS+DOF_BITS-1:0] vrd_q;
	logic [EKEY_BITS+DOF_BITS-1:0] erd_q;

	logic [VKEY_BITS-1:0] cur_vkey;
	logic [EKEY_BITS-1:0] cur_ekey;
	logic [IDX_W-1:0] cnt_sel;
	logic miss, hit, tbl_full, last_lookup;
	logic [DOF_BITS-1:0] hit_dof;
	logic [5:0] amt;
	logic [DOF_BITS:0] sum;
	logic [DOF_BITS-1:0] alloc_next;
	logic alloc_err;
	logic vwe, ewe;
	logic [2:0] pm1_in;

	function automatic logic [VKEY_BITS-1:0] corner_key(input logic [1:0] c,
		input logic [COORD_BITS-1:0] xa, input logic [COORD_BITS-1:0] ya,
		input logic [COORD_BITS-1:0] xb, input logic [COORD_BITS-1:0] yb);
		logic [VKEY_BITS-1:0] r;
		case (c)
			2'd0: r = {xa, ya};
			2'd1: r = {xb, ya};
			2'd2: r = {xb, yb};
			default: r = {xa, yb};
		endcase
		return r;
	endfunction

	always_comb begin
		logic [1:0] ea, eb;
		case (k_q)
			2'd0: begin ea = 2'd0; eb = 2'd1; end
			2'd1: begin ea = 2'd1; eb = 2'd2; end
			2'd2: begin ea = 2'd3; eb = 2'd2; end
			default: begin ea = 2'd0; eb = 2'd3; end
		endcase
		cur_vkey = corner_key(k_q, x1_q, y1_q, x2_q, y2_q);
		cur_ekey = {corner_key(ea, x1_q, y1_q, x2_q, y2_q),
			corner_key(eb, x1_q, y1_q, x2_q, y2_q)};
	end

	assign cnt_sel = edge_q ? IDX_W'(ecnt_q) : IDX_W'(vcnt_q);
	assign tbl_full = edge_q ? (ecnt_q == EC_W'(EDGE_ENTRIES))
		: (vcnt_q == VC_W'(VERTEX_ENTRIES));
	assign miss = (idx_q == cnt_sel);
	assign hit = edge_q ? (erd_q[EKEY_BITS+DOF_BITS-1:DOF_BITS] == cur_ekey)
		: (vrd_q[VKEY_BITS+DOF_BITS-1:DOF_BITS] == cur_vkey);
	assign hit_dof = edge_q ? erd_q[DOF_BITS-1:0] : vrd_q[DOF_BITS-1:0];
	assign last_lookup = edge_q && (k_q == 2'd3);
	assign pm1_in = (poly_order == 3'd0) ? 3'd0 : poly_order - 3'd1;

	always_comb begin
		if (state_q == ST_INT) begin
			amt = pm1sq_q;
		end else if (edge_q) begin
			amt = {3'd0, pm1_q};
		end else begin
			amt = 6'd1;
		end
		sum = {1'b0, next_q} + (DOF_BITS+1)'(amt);
		alloc_next = (sum > {1'b0, DOF_MAX}) ? DOF_MAX : sum[DOF_BITS-1:0];
		alloc_err = (sum > ({1'b0, DOF_MAX} + (DOF_BITS+1)'(1)));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid && item.level == LEVEL_NUMBERED) state_d = ST_RD;
			end
			ST_RD: begin
				if (miss) begin
					state_d = last_lookup ? ST_INT : ST_RD;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (hit && last_lookup) begin
					state_d = ST_INT;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_INT: state_d = ST_PUSH;
			ST_PUSH: begin
				if (!queue_full) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_stall = (state_q != ST_IDLE);
		push = (state_q == ST_PUSH) && !queue_full;
		vwe = (state_q == ST_RD) && miss && !tbl_full && !edge_q;
		ewe = (state_q == ST_RD) && miss && !tbl_full && edge_q;
	end

	always_comb begin
		rec.vals = vals_q;
		rec.pm1 = pm1_q;
		rec.pm1sq = pm1sq_q;
		rec.last_slot = 6'd3 + {1'b0, pm1_q, 2'b00} + pm1sq_q;
		rec.err = err_q;
	end

	always_ff @(posedge clk) begin
		if (vwe) vmem[vcnt_q[VA_W-1:0]] <= {cur_vkey, next_q};
		if (ewe) emem[ecnt_q[EA_W-1:0]] <= {cur_ekey, next_q};
		vrd_q <= vmem[idx_q[VA_W-1:0]];
		erd_q <= emem[idx_q[EA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) begin
			x1_q <= item.left_x;
			y1_q <= item.bottom_y;
			x2_q <= item.right_x;
			y2_q <= item.top_y;
			pm1_q <= pm1_in;
			pm1sq_q <= 6'({3'd0, pm1_in} * {3'd0, pm1_in});
		end
		if (state_q == ST_RD && miss) vals_q[{1'b0, edge_q, k_q}] <= next_q;
		if (state_q == ST_CMP && hit) vals_q[{1'b0, edge_q, k_q}] <= hit_dof;
		if (state_q == ST_INT) vals_q[SEG_INTERIOR] <= next_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			edge_q <= 1'b0;
			k_q <= 2'd0;
			idx_q <= '0;
			vcnt_q <= '0;
			ecnt_q <= '0;
			next_q <= DOF_ONE;
			err_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					edge_q <= 1'b0;
					k_q <= 2'd0;
					idx_q <= '0;
					if (item_valid && item.mesh_start) begin
						vcnt_q <= '0;
						ecnt_q <= '0;
						next_q <= DOF_ONE;
						err_q <= 1'b0;
					end
				end
				ST_RD: begin
					if (miss) begin
						next_q <= alloc_next;
						err_q <= err_q | alloc_err | tbl_full;
						if (vwe) vcnt_q <= vcnt_q + VC_W'(1);
						if (ewe) ecnt_q <= ecnt_q + EC_W'(1);
						idx_q <= '0;
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3) edge_q <= 1'b1;
					end
				end
				ST_CMP: begin
					if (hit) begin
						idx_q <= '0;
						k_q <= k_q + 2'd1;
						if (k_q == 2'd3) edge_q <= 1'b1;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_INT: begin
					next_q <= alloc_next;
					err_q <= err_q | alloc_err;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[design/fde_queue.sv]
// fde_queue: two-entry queue of element records between front and back.
// depends on fde_pkg.
`timescale 1ns / 1ps
module fde_queue import fde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  elem_t push_rec,
	output logic full,
	input  logic pop,
	output logic rec_valid,
	output elem_t head
);

	localparam int DEPTH = 2;

	elem_t mem_q [DEPTH];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(DEPTH));
	assign rec_valid = (cnt_q != 2'd0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[design/fde_back.sv]
// fde_back: walks one element record and emits every number with its slot,
// last flag and error flag through an output register. depends on fde_pkg.
`timescale 1ns / 1ps
module fde_back import fde_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic rec_valid,
	input  elem_t rec,
	output logic pop,
	output logic result_valid,
	input  logic result_stall,
	output result_t result
);

	logic [3:0] seg_q;
	logic [5:0] i_q;
	logic [5:0] slot_q;
	logic out_valid_q;
	result_t out_q;

	logic adv, last;
	logic [DOF_BITS-1:0] base;
	logic [DOF_BITS:0] sum;
	logic [5:0] seg_len;

	assign adv = rec_valid && (!out_valid_q || !result_stall);
	assign last = (slot_q == rec.last_slot);
	assign pop = adv && last;
	assign base = rec.vals[seg_q];
	assign sum = {1'b0, base} + (DOF_BITS+1)'(i_q);
	assign seg_len = (seg_q == 4'(SEG_INTERIOR)) ? rec.pm1sq : {3'd0, rec.pm1};
	assign result_valid = out_valid_q;
	assign result = out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.dof_number <= (sum > {1'b0, DOF_MAX}) ? DOF_MAX : sum[DOF_BITS-1:0];
			out_q.slot_index <= slot_q;
			out_q.last_of_element <= last;
			out_q.overflow_error <= rec.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= 4'd0;
			i_q <= 6'd0;
			slot_q <= 6'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				if (last) begin
					seg_q <= 4'd0;
					i_q <= 6'd0;
					slot_q <= 6'd0;
				end else begin
					slot_q <= slot_q + 6'd1;
					if (seg_q < 4'd4 || i_q + 6'd1 == seg_len) begin
						seg_q <= seg_q + 4'd1;
						i_q <= 6'd0;
					end else begin
						i_q <= i_q + 6'd1;
					end
				end
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/fem_dof_enumerator_top.sv]
// fem_dof_enumerator_top: dof numbering of level-1 quad elements.
// depends on fde_pkg, fde_front, fde_queue, fde_back.
//
// channel   dir  handshake              word
// item      in   item_valid/item_stall  item_t
// result    out  result_valid/stall     result_t
// cfg       in   cfg_valid/cfg_ready    poly_order (3 bits)
//
// front: accepts an element, scans the tables via read/compare for each of
// 8 lookups, allocates on a miss, then for the interior; grows with fill counts.
// back: a number per unstalled cycle, 4+4(p-1)+(p-1)^2 per element, p 0 as 1.
// reset clears fill counts, counter to 1, error flag; no clearing pass.
// a two-record queue lets the front keep scanning while the result side stalls.
`timescale 1ns / 1ps
module fem_dof_enumerator_top import fde_pkg::*; #(
	parameter int VERTEX_ENTRIES = DEF_VERTEX_ENTRIES,
	parameter int EDGE_ENTRIES = DEF_EDGE_ENTRIES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  item_t item,
	output logic result_valid,
	input  logic result_stall,
	output result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_data
);

	logic [2:0] order_q;
	logic push, qfull, pop, rec_valid;
	elem_t push_rec, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			order_q <= cfg_data;
		end
	end

	fde_front #(
		.VERTEX_ENTRIES(VERTEX_ENTRIES),
		.EDGE_ENTRIES(EDGE_ENTRIES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.poly_order(order_q),
		.push(push),
		.queue_full(qfull),
		.rec(push_rec)
	);

	fde_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_rec(push_rec),
		.full(qfull),
		.pop(pop),
		.rec_valid(rec_valid),
		.head(head)
	);

	fde_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec(head),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule
